/* hdl/cstg_pkg.sv */
// constants, types, sine table and control store for the compensated sine tone generator
package cstg_pkg;

  // tone setup
  localparam int TICK_RATE        = 44100;
  localparam int PEAK_GAIN        = 300000;
  localparam int SINE_INDEX_BITS  = 10;

  // field widths
  localparam int FREQ_W   = 19;
  localparam int SAMPLE_W = 16;
  localparam int PHASE_W  = 32;

  // quarter-wave sine table
  localparam int QUARTER_BITS = SINE_INDEX_BITS - 2;
  localparam int QUARTER_SIZE = 1 << QUARTER_BITS;
  localparam int SINE_W       = 15;
  localparam longint unsigned SINE_MAX = 64'd32767;

  // polynomial coefficients, Q1.30
  localparam longint unsigned K1 = 64'd1686629713;
  localparam longint unsigned K3 = 64'd693598668;
  localparam longint unsigned K5 = 64'd85569306;
  localparam longint unsigned K7 = 64'd5026994;
  localparam longint unsigned K9 = 64'd172272;

  // phase increment split: f * 2^28 / rate = f * INC_A + f * INC_B / rate
  localparam int INC_A  = (1 << 28) / TICK_RATE;
  localparam int INC_B  = (1 << 28) % TICK_RATE;
  localparam int A_W    = $clog2(INC_A + 1);
  localparam int RATE_W = $clog2(TICK_RATE + 1);
  localparam int AMP_W  = $clog2(PEAK_GAIN + 1);

  // f * INC_B / rate as f * INC_M >> INC_K, INC_M rounded up; 2^INC_K covers
  // every 19-bit f times the rate, so the floor comes out exact
  localparam int INC_K    = FREQ_W + RATE_W;
  localparam int INC_LO_W = 17;
  localparam int INC_HI_W = INC_K - INC_LO_W;
  localparam longint unsigned INC_M =
    ((64'(INC_B) << INC_K) + 64'(TICK_RATE - 1)) / 64'(TICK_RATE);
  localparam longint unsigned INC_M_LO = INC_M & ((64'd1 << INC_LO_W) - 64'd1);
  localparam longint unsigned INC_M_HI = INC_M >> INC_LO_W;

  // multiplier
  localparam int MUL_X_W  = FREQ_W;
  localparam int MUL_Y_AB = (A_W > AMP_W) ? A_W : AMP_W;
  localparam int MUL_Y_C  = (INC_HI_W > INC_LO_W) ? INC_HI_W : INC_LO_W;
  localparam int MUL_Y_W  = (MUL_Y_AB > MUL_Y_C) ? MUL_Y_AB : MUL_Y_C;
  localparam int PROD_W   = MUL_X_W + MUL_Y_W;
  localparam int AMPN_W   = SINE_W + AMP_W;

  // square root of f * 2^20
  localparam int SQRT_SHIFT = 20;
  localparam int ROOT_W     = (FREQ_W + SQRT_SHIFT + 1) / 2;
  localparam int SQ_IN_W    = 2 * ROOT_W - SQRT_SHIFT;
  localparam int SQ_REM_W   = ROOT_W + 3;
  // three root steps ride along with the increment and phase steps
  localparam int SQRT_LOOP_STEPS = ROOT_W - 3;

  // restoring divider for the amplitude
  localparam int AMP_D_W    = ROOT_W + 3;
  localparam int DIV_D_W    = AMP_D_W;
  localparam int DIV_REM_W  = DIV_D_W + 1;
  localparam int DIV_FEED_W = FREQ_W;
  localparam int DIV_Q_W    = FREQ_W;
  localparam int AMP_STEPS  = SAMPLE_W;
  localparam int LP_W       = $clog2((SQRT_LOOP_STEPS > AMP_STEPS) ? SQRT_LOOP_STEPS
                                                                   : AMP_STEPS);

  // control store
  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] STEP_IDLE      = 4'd0;
  localparam logic [PC_W-1:0] STEP_CHECK     = 4'd1;
  localparam logic [PC_W-1:0] STEP_INC_HI    = 4'd2;
  localparam logic [PC_W-1:0] STEP_INC_A     = 4'd3;
  localparam logic [PC_W-1:0] STEP_PHASE     = 4'd4;
  localparam logic [PC_W-1:0] STEP_SQRT_LOOP = 4'd5;
  localparam logic [PC_W-1:0] STEP_LOOKUP    = 4'd6;
  localparam logic [PC_W-1:0] STEP_SCALE     = 4'd7;
  localparam logic [PC_W-1:0] STEP_AMP_INIT  = 4'd8;
  localparam logic [PC_W-1:0] STEP_AMP_LOOP  = 4'd9;
  localparam logic [PC_W-1:0] STEP_EMIT      = 4'd10;

  typedef enum logic [1:0] {
    HOLD_NONE     = 2'd0,
    HOLD_NO_START = 2'd1,
    HOLD_OUT_BUSY = 2'd2
  } hold_t;

  typedef enum logic [1:0] {
    JMP_NEVER  = 2'd0,
    JMP_ALWAYS = 2'd1,
    JMP_SILENT = 2'd2,
    JMP_LOOP   = 2'd3
  } jump_t;

  typedef enum logic [2:0] {
    MUL_NONE  = 3'd0,
    MUL_F_LO  = 3'd1,
    MUL_F_HI  = 3'd2,
    MUL_F_A   = 3'd3,
    MUL_S_AMP = 3'd4
  } mul_t;

  typedef struct packed {
    hold_t           hold;
    jump_t           jump;
    logic [PC_W-1:0] target;
    mul_t            mul;
    logic            take_in;
    logic            sqrt_init;
    logic            sqrt_step;
    logic            inc_lo;
    logic            inc_hi;
    logic            div_init_amp;
    logic            div_step;
    logic            phase_upd;
    logic            rom_rd;
    logic            emit;
  } ctrl_t;

  localparam ctrl_t CW_NOP = '{
    hold: HOLD_NONE, jump: JMP_NEVER, target: STEP_IDLE, mul: MUL_NONE, default: 1'b0
  };

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = CW_NOP;
    case (pc)
      STEP_IDLE: begin
        w.hold    = HOLD_NO_START;
        w.take_in = 1'b1;
      end
      STEP_CHECK: begin
        w.jump      = JMP_SILENT;
        w.target    = STEP_EMIT;
        w.mul       = MUL_F_LO;
        w.sqrt_init = 1'b1;
      end
      STEP_INC_HI: begin
        w.mul       = MUL_F_HI;
        w.inc_lo    = 1'b1;
        w.sqrt_step = 1'b1;
      end
      STEP_INC_A: begin
        w.mul       = MUL_F_A;
        w.inc_hi    = 1'b1;
        w.sqrt_step = 1'b1;
      end
      STEP_PHASE: begin
        w.sqrt_step = 1'b1;
        w.phase_upd = 1'b1;
      end
      STEP_SQRT_LOOP: begin
        w.jump      = JMP_LOOP;
        w.target    = STEP_SQRT_LOOP;
        w.sqrt_step = 1'b1;
      end
      STEP_LOOKUP: begin
        w.rom_rd = 1'b1;
      end
      STEP_SCALE: begin
        w.mul = MUL_S_AMP;
      end
      STEP_AMP_INIT: begin
        w.div_init_amp = 1'b1;
      end
      STEP_AMP_LOOP: begin
        w.jump     = JMP_LOOP;
        w.target   = STEP_AMP_LOOP;
        w.div_step = 1'b1;
      end
      STEP_EMIT: begin
        w.hold   = HOLD_OUT_BUSY;
        w.jump   = JMP_ALWAYS;
        w.target = STEP_IDLE;
        w.emit   = 1'b1;
      end
      default: begin
        w.jump   = JMP_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  typedef logic [QUARTER_SIZE-1:0][SINE_W-1:0] sine_rom_t;

  // entry i sampled at the middle of its slot, odd polynomial in Q1.30
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t       rom;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned acc;
    longint unsigned v;
    for (int i = 0; i < QUARTER_SIZE; i++) begin
      t   = longint'(2 * i + 1) << (29 - QUARTER_BITS);
      t2  = (t * t) >> 30;
      acc = K7 - ((t2 * K9) >> 30);
      acc = K5 - ((t2 * acc) >> 30);
      acc = K3 - ((t2 * acc) >> 30);
      acc = K1 - ((t2 * acc) >> 30);
      acc = (t * acc) >> 30;
      v   = (acc * SINE_MAX + (64'd1 << 29)) >> 30;
      if (v > SINE_MAX) begin
        v = SINE_MAX;
      end
      rom[i] = v[SINE_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

/* hdl/compensated_sine_tone_generator_top.sv */
// sine tone generator with loudness-compensated amplitude, microcoded datapath
//
// Each input beat is one audio sample tick carrying note_on and a frequency in
// 1/16 Hz; each produces exactly one output beat. A sounding tick advances the
// 32-bit phase by f*2^28/44100, looks up a quarter-wave sine table and scales
// it by 300000/sqrt(f in Hz), truncating and saturating to 16 bits. A silent
// tick (note off or zero frequency) gives 0 and leaves the phase alone. After
// accepting a tick the input stays stalled until its sample has been passed to
// the output register, so a new tick is never taken while one is in flight. A
// sounding tick runs the 20-step square root, which covers the phase increment
// (integer part plus a reciprocal multiply for the fraction), and the 16-step
// restoring divide for the amplitude scaling. The input is taken only at the
// idle step; a finished sample waits in the output register, so the next tick
// may be accepted while it is stalled.
module compensated_sine_tone_generator_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  note_on,
  input  logic [cstg_pkg::FREQ_W-1:0]           freq_sixteenths,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [cstg_pkg::SAMPLE_W-1:0]  sample_out
);

  localparam logic [cstg_pkg::SAMPLE_W:0] POS_MAX =
    (cstg_pkg::SAMPLE_W + 1)'((1 << (cstg_pkg::SAMPLE_W - 1)) - 1);
  localparam logic [cstg_pkg::SAMPLE_W:0] NEG_MAX =
    (cstg_pkg::SAMPLE_W + 1)'(1 << (cstg_pkg::SAMPLE_W - 1));

  // sequencer
  logic [cstg_pkg::PC_W-1:0] pc;
  logic [cstg_pkg::PC_W-1:0] pc_next;
  cstg_pkg::ctrl_t           cw;
  logic                      hold;
  logic                      jump_taken;
  logic                      accept;
  logic                      emit_en;

  // captured beat
  logic                        tone_on;
  logic [cstg_pkg::FREQ_W-1:0] freq;
  logic                        silent;

  // multiplier
  logic [cstg_pkg::MUL_X_W-1:0] mul_x;
  logic [cstg_pkg::MUL_Y_W-1:0] mul_y;
  logic [cstg_pkg::PROD_W-1:0]  prod;

  // fractional part of the phase increment
  logic [cstg_pkg::FREQ_W-1:0] frac_lo;
  logic [cstg_pkg::FREQ_W-1:0] frac;
  logic [cstg_pkg::PROD_W-1:0] frac_sum;

  // divider
  logic [cstg_pkg::DIV_REM_W-1:0]  div_rem;
  logic [cstg_pkg::DIV_D_W-1:0]    div_d;
  logic [cstg_pkg::DIV_FEED_W-1:0] div_feed;
  logic [cstg_pkg::DIV_Q_W-1:0]    div_q;
  logic [cstg_pkg::LP_W-1:0]       lp;
  logic                            ovf;
  logic [cstg_pkg::DIV_REM_W-1:0]  div_r2;
  logic [cstg_pkg::DIV_REM_W-1:0]  div_dx;
  logic                            div_ge;

  // square root
  logic [cstg_pkg::SQ_IN_W-1:0]  sq_in;
  logic [cstg_pkg::SQ_REM_W-1:0] sq_rem;
  logic [cstg_pkg::ROOT_W-1:0]   root;
  logic [cstg_pkg::SQ_REM_W-1:0] sq_r2;
  logic [cstg_pkg::SQ_REM_W-1:0] sq_trial;
  logic                          sq_ge;

  // amplitude divide setup
  logic [cstg_pkg::AMPN_W-cstg_pkg::SAMPLE_W-1:0] amp_hi;
  logic [cstg_pkg::AMP_D_W-1:0]                   amp_d;

  // phase and table
  logic [cstg_pkg::PHASE_W-1:0]      phase;
  logic [cstg_pkg::QUARTER_BITS-1:0] rom_k;
  logic [cstg_pkg::QUARTER_BITS-1:0] rom_addr;
  logic [cstg_pkg::SINE_W-1:0]       sine;
  logic                              neg;

  // result
  logic [cstg_pkg::SAMPLE_W:0]   mag;
  logic                          big;
  logic [cstg_pkg::SAMPLE_W-1:0] sample_next;

  assign cw       = cstg_pkg::ucode(pc);
  assign in_stall = !cw.take_in;
  assign accept   = in_valid && cw.take_in;
  assign silent   = !tone_on || (freq == '0);

  always_comb begin
    case (cw.hold)
      cstg_pkg::HOLD_NONE:     hold = 1'b0;
      cstg_pkg::HOLD_NO_START: hold = !in_valid;
      cstg_pkg::HOLD_OUT_BUSY: hold = out_valid && out_stall;
      default:                 hold = 1'b0;
    endcase
  end

  always_comb begin
    case (cw.jump)
      cstg_pkg::JMP_NEVER:  jump_taken = 1'b0;
      cstg_pkg::JMP_ALWAYS: jump_taken = 1'b1;
      cstg_pkg::JMP_SILENT: jump_taken = silent;
      cstg_pkg::JMP_LOOP:   jump_taken = (lp != '0);
      default:              jump_taken = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      pc_next = pc;
    end else if (jump_taken) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  assign emit_en = cw.emit && !hold;

  always_comb begin
    case (cw.mul)
      cstg_pkg::MUL_F_LO: begin
        mul_x = freq;
        mul_y = cstg_pkg::MUL_Y_W'(cstg_pkg::INC_M_LO);
      end
      cstg_pkg::MUL_F_HI: begin
        mul_x = freq;
        mul_y = cstg_pkg::MUL_Y_W'(cstg_pkg::INC_M_HI);
      end
      cstg_pkg::MUL_F_A: begin
        mul_x = freq;
        mul_y = cstg_pkg::MUL_Y_W'(cstg_pkg::INC_A);
      end
      cstg_pkg::MUL_S_AMP: begin
        mul_x = cstg_pkg::MUL_X_W'(sine);
        mul_y = cstg_pkg::MUL_Y_W'(cstg_pkg::PEAK_GAIN);
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  // f * INC_M >> INC_K from two partial products
  assign frac_sum = prod + cstg_pkg::PROD_W'(frac_lo);

  // one restoring step per cycle, remainder kept below the divisor unless the quotient overflows
  assign div_r2 = {div_rem[cstg_pkg::DIV_REM_W-2:0], div_feed[cstg_pkg::DIV_FEED_W-1]};
  assign div_dx = cstg_pkg::DIV_REM_W'(div_d);
  assign div_ge = (div_r2 >= div_dx);

  // digit-by-digit root, two radicand bits per step
  assign sq_r2    = {sq_rem[cstg_pkg::SQ_REM_W-3:0], sq_in[cstg_pkg::SQ_IN_W-1 -: 2]};
  assign sq_trial = cstg_pkg::SQ_REM_W'({root, 2'b01});
  assign sq_ge    = (sq_r2 >= sq_trial);

  assign amp_hi = prod[cstg_pkg::AMPN_W-1:cstg_pkg::SAMPLE_W];
  assign amp_d  = {root, 3'b000};

  // second and fourth quadrants read the table mirrored
  assign rom_k    = phase[cstg_pkg::PHASE_W-cstg_pkg::SINE_INDEX_BITS +: cstg_pkg::QUARTER_BITS];
  assign rom_addr = phase[cstg_pkg::PHASE_W-2] ? ~rom_k : rom_k;

  always_comb begin
    mag = div_q[cstg_pkg::SAMPLE_W:0];
    big = ovf || (div_q[cstg_pkg::DIV_Q_W-1:cstg_pkg::SAMPLE_W+1] != '0);
    if (silent) begin
      sample_next = '0;
    end else if (neg) begin
      if (big || mag > NEG_MAX) begin
        sample_next = NEG_MAX[cstg_pkg::SAMPLE_W-1:0];
      end else begin
        sample_next = '0 - mag[cstg_pkg::SAMPLE_W-1:0];
      end
    end else begin
      if (big || mag > POS_MAX) begin
        sample_next = POS_MAX[cstg_pkg::SAMPLE_W-1:0];
      end else begin
        sample_next = mag[cstg_pkg::SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= cstg_pkg::STEP_IDLE;
      out_valid <= 1'b0;
      phase     <= '0;
    end else begin
      pc <= pc_next;
      if (emit_en) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cw.phase_upd) begin
        phase <= phase + prod[cstg_pkg::PHASE_W-1:0] + cstg_pkg::PHASE_W'(frac);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tone_on <= note_on;
      freq    <= freq_sixteenths;
    end
    if (cw.mul != cstg_pkg::MUL_NONE) begin
      prod <= mul_x * mul_y;
    end

    if (cw.inc_lo) begin
      frac_lo <= prod[cstg_pkg::INC_LO_W +: cstg_pkg::FREQ_W];
    end
    if (cw.inc_hi) begin
      frac <= frac_sum[cstg_pkg::INC_HI_W +: cstg_pkg::FREQ_W];
    end

    if (cw.div_init_amp) begin
      div_rem  <= cstg_pkg::DIV_REM_W'(amp_hi);
      div_feed <= cstg_pkg::DIV_FEED_W'(prod[cstg_pkg::SAMPLE_W-1:0])
                  << (cstg_pkg::DIV_FEED_W - cstg_pkg::SAMPLE_W);
      div_d    <= cstg_pkg::DIV_D_W'(amp_d);
      div_q    <= '0;
      // quotient of 2^16 or more saturates whatever the sign
      ovf      <= (cstg_pkg::DIV_REM_W'(amp_hi) >= cstg_pkg::DIV_REM_W'(amp_d));
    end else if (cw.div_step) begin
      div_rem  <= div_ge ? (div_r2 - div_dx) : div_r2;
      div_feed <= div_feed << 1;
      div_q    <= {div_q[cstg_pkg::DIV_Q_W-2:0], div_ge};
    end

    if (cw.sqrt_init) begin
      lp <= cstg_pkg::LP_W'(cstg_pkg::SQRT_LOOP_STEPS - 1);
    end else if (cw.div_init_amp) begin
      lp <= cstg_pkg::LP_W'(cstg_pkg::AMP_STEPS - 1);
    end else if (cw.jump == cstg_pkg::JMP_LOOP) begin
      lp <= lp - 1'b1;
    end

    if (cw.sqrt_init) begin
      sq_in  <= cstg_pkg::SQ_IN_W'(freq);
      sq_rem <= '0;
      root   <= '0;
    end else if (cw.sqrt_step) begin
      sq_in  <= sq_in << 2;
      sq_rem <= sq_ge ? (sq_r2 - sq_trial) : sq_r2;
      root   <= {root[cstg_pkg::ROOT_W-2:0], sq_ge};
    end

    if (cw.rom_rd) begin
      sine <= cstg_pkg::SINE_ROM[rom_addr];
      neg  <= phase[cstg_pkg::PHASE_W-1];
    end
    if (emit_en) begin
      sample_out <= sample_next;
    end
  end

`ifndef SYNTHESIS
  a_div_rem_bounded: assert property (@(posedge clk) disable iff (rst)
    (cw.div_step && !ovf) |-> (div_rem < div_dx))
    else $error("divider remainder not below divisor");

  a_sqrt_rem_bounded: assert property (@(posedge clk) disable iff (rst)
    cw.sqrt_step |-> (sq_rem <= cstg_pkg::SQ_REM_W'({root, 1'b0})))
    else $error("square root remainder out of range");

  a_silent_zero: assert property (@(posedge clk) disable iff (rst)
    (emit_en && silent) |=> (out_valid && sample_out == '0))
    else $error("silent tick did not give a zero sample");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(emit_en))
    else $error("output beat raised outside the emit step");
`endif

endmodule
